[hw/rtl/jsu_pkg.sv]
// Shared types, codes and constants for the JSON string unescaper.
package jsu_pkg;

   // Result type codes carried on rsp_tuser.
   localparam logic [1:0] RT_DATA  = 2'd0;
   localparam logic [1:0] RT_CLOSE = 2'd1;
   localparam logic [1:0] RT_ERR   = 2'd2;

   // Commands passed from the front end to the back end.
   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_ERR   = 2'd2;
   localparam logic [1:0] CMD_UTF8  = 2'd3;

   // UTF-8 encoding constants.
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

   // Default depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] value;
   } cmd_type;

endpackage

[hw/rtl/jsu_front.sv]
// Front end: accepts text bytes, tracks string and escape state, and issues commands.
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       queue_full,
   output logic       push_valid,
   output cmd_type    push_cmd
);

   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_STR  = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;
   localparam logic [1:0] MODE_HEX  = 2'd3;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_U = 8'h75;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;

   logic        accept;
   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] code_point_next;

   // Decodes one ASCII hex digit; hex_ok is low for any other byte.
   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         hex_digit = req_tdata[3:0];
      end else if ((req_tdata >= 8'h41 && req_tdata <= 8'h46) ||
                   (req_tdata >= 8'h61 && req_tdata <= 8'h66)) begin
         hex_digit = req_tdata[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign req_tready      = ~queue_full;
   assign accept          = req_tvalid & req_tready;
   assign code_point_next = {code_point_ff[11:0], hex_digit};

   always_comb begin
      mode_in        = mode_ff;
      hex_count_in   = hex_count_ff;
      code_point_in  = code_point_ff;
      push_valid     = 1'b0;
      push_cmd.op    = CMD_BYTE;
      push_cmd.value = {8'd0, req_tdata};
      if (accept) begin
         if (req_tuser) begin
            if (mode_ff != MODE_WAIT) begin
               mode_in       = MODE_WAIT;
               hex_count_in  = 2'd0;
               code_point_in = 16'd0;
               push_valid    = 1'b1;
               push_cmd.op   = CMD_ERR;
            end
         end else begin
            unique case (mode_ff)
               MODE_WAIT: begin
                  if (req_tdata == CH_QUOTE) begin
                     mode_in = MODE_STR;
                  end else begin
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                     push_valid    = 1'b1;
                     push_cmd.op   = CMD_ERR;
                  end
               end
               MODE_STR: begin
                  if (req_tdata == CH_QUOTE) begin
                     mode_in       = MODE_WAIT;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                     push_valid    = 1'b1;
                     push_cmd.op   = CMD_CLOSE;
                  end else if (req_tdata == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     push_valid = 1'b1;
                  end
               end
               MODE_ESC: begin
                  mode_in    = MODE_STR;
                  push_valid = 1'b1;
                  unique case (req_tdata)
                     CH_B: push_cmd.value = 16'h0008;
                     CH_F: push_cmd.value = 16'h000C;
                     CH_N: push_cmd.value = 16'h000A;
                     CH_R: push_cmd.value = 16'h000D;
                     CH_T: push_cmd.value = 16'h0009;
                     CH_U: begin
                        mode_in       = MODE_HEX;
                        hex_count_in  = 2'd0;
                        code_point_in = 16'd0;
                        push_valid    = 1'b0;
                     end
                     default: push_cmd.value = {8'd0, req_tdata};
                  endcase
               end
               MODE_HEX: begin
                  if (!hex_ok) begin
                     mode_in       = MODE_WAIT;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                     push_valid    = 1'b1;
                     push_cmd.op   = CMD_ERR;
                  end else if (hex_count_ff == 2'd3) begin
                     mode_in        = MODE_STR;
                     hex_count_in   = 2'd0;
                     code_point_in  = 16'd0;
                     push_valid     = 1'b1;
                     push_cmd.op    = CMD_UTF8;
                     push_cmd.value = code_point_next;
                  end else begin
                     hex_count_in  = hex_count_ff + 2'd1;
                     code_point_in = code_point_next;
                  end
               end
               default: mode_in = MODE_WAIT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_WAIT;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
      end else begin
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
      end
   end

endmodule

[hw/rtl/jsu_queue.sv]
// Command queue that decouples the front end from the back end.
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hw/rtl/jsu_back.sv]
// Back end: expands each command into one to three results in an output register.
module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic [1:0] step_ff, step_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0] rsp_tuser_ff, rsp_tuser_in;
   logic       rsp_tlast_ff, rsp_tlast_in;

   logic       out_free;
   logic       emit;
   logic [1:0] last_step;
   logic [7:0] byte_sel;
   logic [1:0] type_sel;
   logic [15:0] cp;

   assign cp       = head_cmd.value;
   assign out_free = ~rsp_tvalid_ff | rsp_tready;
   assign emit     = ~queue_empty & out_free;

   // Index of the final result of the head command.
   always_comb begin
      last_step = 2'd0;
      if (head_cmd.op == CMD_UTF8) begin
         if (cp < UTF8_ONE_LIMIT) begin
            last_step = 2'd0;
         end else if (cp < UTF8_TWO_LIMIT) begin
            last_step = 2'd1;
         end else begin
            last_step = 2'd2;
         end
      end
   end

   always_comb begin
      byte_sel = 8'd0;
      type_sel = RT_DATA;
      unique case (head_cmd.op)
         CMD_BYTE:  byte_sel = cp[7:0];
         CMD_CLOSE: type_sel = RT_CLOSE;
         CMD_ERR:   type_sel = RT_ERR;
         CMD_UTF8: begin
            priority if (last_step == 2'd0) begin
               byte_sel = cp[7:0];
            end else if (last_step == 2'd1) begin
               byte_sel = (step_ff == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]})
                                            : (UTF8_CONT | {2'd0, cp[5:0]});
            end else begin
               unique case (step_ff)
                  2'd0:    byte_sel = UTF8_LEAD3 | {4'd0, cp[15:12]};
                  2'd1:    byte_sel = UTF8_CONT | {2'd0, cp[11:6]};
                  default: byte_sel = UTF8_CONT | {2'd0, cp[5:0]};
               endcase
            end
         end
         default: type_sel = RT_ERR;
      endcase
   end

   always_comb begin
      step_in       = step_ff;
      pop           = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = byte_sel;
         rsp_tuser_in  = type_sel;
         rsp_tlast_in  = (step_ff == last_step);
         if (step_ff == last_step) begin
            pop     = 1'b1;
            step_in = 2'd0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

[hw/rtl/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper: front end, command queue and UTF-8 back end.
// A request that yields output is pushed as a command into the queue; the back end then registers its results.
// Throughput: one request per cycle; the back end emits one result per cycle while rsp_tready is high, so a
// \u escape that encodes to two or three UTF-8 bytes holds the output until all of its bytes are taken.
// The command queue absorbs such bursts; requests stall only when it is full.
// Reset (synchronous, active high) returns to waiting for an opening quote and empties the queue.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   // Request channel: one text byte per request.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] kind: 0 data byte, 1 end of input
   // Result channel: one decoded byte or status per result.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] result_type: 0 data, 1 closed, 2 error
   output logic       rsp_tlast    // last result caused by the request
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;

   // The front end decodes string, escape and hex-digit state one byte per cycle while the queue is not
   // full, and turns every request that yields output into a single command.
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // The queue lets the front end keep taking bytes while the back end drains a burst.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_cmd   (head_cmd)
   );

   // The back end expands a command into its results and registers each one.
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[sim/json_string_unescape_utf8_test.sv]
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Request kinds carried on req_tuser.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Text characters that steer the decoder.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_G         = 8'h67;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;

   // Control characters produced by the short escapes.
   localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTRL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTRL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTRL_RETURN    = 8'h0D;
   localparam logic [7:0] CTRL_TAB       = 8'h09;

   localparam int IDLE_PERCENT   = 14;
   localparam int RANDOM_ITEMS   = 340;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      WAIT_QUOTE,
      IN_STRING,
      AFTER_BACKSLASH,
      IN_HEX
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] result_type;
      logic       last_of_run;
   } decoded_result_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = KIND_DATA;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   // Shadow copy of the decoder state, advanced once per accepted request.
   parse_mode_type parse_mode  = WAIT_QUOTE;
   logic [1:0]     hex_digits  = 2'd0;
   logic [15:0]    code_accum  = 16'h0000;

   decoded_result_type pending_results[$];

   bit no_gaps = 1'b0;
   int cycle_count = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int strings_closed = 0;
   int errors_seen = 0;

   json_string_unescape_utf8 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("json_string_unescape_utf8: mismatch");
         $finish;
      end
   end

   // The result side stalls at random, except during the gap-free stretch.
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   function automatic int hex_nibble(input logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return int'(ch - CH_UPPER_A) + 10;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return int'(ch - CH_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit upper);
      if (nibble < 4'd10) return CH_ZERO + 8'(nibble);
      return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nibble) - 8'd10;
   endfunction

   function automatic void clear_to_wait();
      parse_mode = WAIT_QUOTE;
      hex_digits = 2'd0;
      code_accum = 16'h0000;
   endfunction

   // Advances the shadow state by one request and queues the results it must cause.
   task automatic predict_unescape(input logic kind, input logic [7:0] ch);
      logic [7:0]         bytes_out [3];
      logic [1:0]         types_out [3];
      decoded_result_type entry;
      logic [15:0]        cp;
      int                 n;
      int                 nib;
      n = 0;
      if (kind == KIND_END) begin
         // End of input is harmless only between strings.
         if (parse_mode != WAIT_QUOTE) begin
            bytes_out[0] = 8'h00;
            types_out[0] = RT_ERR;
            n = 1;
            clear_to_wait();
         end
      end else begin
         case (parse_mode)
            WAIT_QUOTE: begin
               if (ch == CH_QUOTE) begin
                  parse_mode = IN_STRING;
               end else begin
                  bytes_out[0] = 8'h00;
                  types_out[0] = RT_ERR;
                  n = 1;
                  clear_to_wait();
               end
            end
            IN_STRING: begin
               if (ch == CH_QUOTE) begin
                  bytes_out[0] = 8'h00;
                  types_out[0] = RT_CLOSE;
                  n = 1;
                  clear_to_wait();
               end else if (ch == CH_BACKSLASH) begin
                  parse_mode = AFTER_BACKSLASH;
               end else begin
                  bytes_out[0] = ch;
                  types_out[0] = RT_DATA;
                  n = 1;
               end
            end
            AFTER_BACKSLASH: begin
               parse_mode = IN_STRING;
               bytes_out[0] = ch;
               types_out[0] = RT_DATA;
               n = 1;
               case (ch)
                  CH_B: bytes_out[0] = CTRL_BACKSPACE;
                  CH_F: bytes_out[0] = CTRL_FORMFEED;
                  CH_N: bytes_out[0] = CTRL_NEWLINE;
                  CH_R: bytes_out[0] = CTRL_RETURN;
                  CH_T: bytes_out[0] = CTRL_TAB;
                  CH_U: begin
                     parse_mode = IN_HEX;
                     hex_digits = 2'd0;
                     code_accum = 16'h0000;
                     n = 0;
                  end
                  default: ;
               endcase
            end
            IN_HEX: begin
               nib = hex_nibble(ch);
               if (nib < 0) begin
                  bytes_out[0] = 8'h00;
                  types_out[0] = RT_ERR;
                  n = 1;
                  clear_to_wait();
               end else begin
                  code_accum = {code_accum[11:0], 4'(nib)};
                  if (hex_digits == 2'd3) begin
                     cp = code_accum;
                     parse_mode = IN_STRING;
                     hex_digits = 2'd0;
                     code_accum = 16'h0000;
                     types_out = '{RT_DATA, RT_DATA, RT_DATA};
                     if (cp < UTF8_ONE_LIMIT) begin
                        bytes_out[0] = cp[7:0];
                        n = 1;
                     end else if (cp < UTF8_TWO_LIMIT) begin
                        bytes_out[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
                        bytes_out[1] = UTF8_CONT | {2'b00, cp[5:0]};
                        n = 2;
                     end else begin
                        bytes_out[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                        bytes_out[1] = UTF8_CONT | {2'b00, cp[11:6]};
                        bytes_out[2] = UTF8_CONT | {2'b00, cp[5:0]};
                        n = 3;
                     end
                  end else begin
                     hex_digits = hex_digits + 2'd1;
                  end
               end
            end
         endcase
      end
      for (int i = 0; i < n; i++) begin
         entry.out_byte    = bytes_out[i];
         entry.result_type = types_out[i];
         entry.last_of_run = (i == n - 1);
         pending_results = {pending_results, entry};
      end
   endtask

   // Offers one request, waits for it to be taken and records what it should produce.
   // Entered and left at a falling edge.
   task automatic send_request(input logic kind, input logic [7:0] in_byte);
      while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= in_byte;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_unescape(kind, in_byte);
      requests_sent++;
      @(negedge clock);
   endtask

   // Sends a backslash-u escape, cut short after the given number of hex digits.
   task automatic send_unicode_escape(input logic [15:0] cp, input int digits);
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, CH_U);
      for (int i = 0; i < digits; i++) begin
         send_request(KIND_DATA, hex_char(cp[15 - 4 * i -: 4], $urandom_range(0, 1)));
      end
   endtask

   // Random string content: plain bytes, short escapes and full unicode escapes.
   task automatic send_random_body(input int elements);
      logic [7:0] escape_letters [8];
      logic [7:0] ch;
      logic [15:0] cp;
      escape_letters = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BACKSLASH, CH_SLASH};
      for (int e = 0; e < elements; e++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               do ch = 8'($urandom_range(0, 255));
               while (ch == CH_QUOTE || ch == CH_BACKSLASH);
               send_request(KIND_DATA, ch);
            end
            11, 12, 13, 14: begin
               if ($urandom_range(0, 3) != 0) begin
                  ch = escape_letters[$urandom_range(0, 7)];
               end else begin
                  // Any other escaped byte is passed through unchanged.
                  do ch = 8'($urandom_range(0, 255)); while (ch == CH_U);
               end
               send_request(KIND_DATA, CH_BACKSLASH);
               send_request(KIND_DATA, ch);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0:       cp = 16'($urandom_range(0, 16'h007F));
                  1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
               endcase
               send_unicode_escape(cp, 4);
            end
         endcase
      end
   endtask

   // Plain bytes at both ends of the range, a short escape and an escaped pass-through byte.
   task automatic test_plain_and_escapes();
      send_request(KIND_DATA, CH_QUOTE);
      send_request(KIND_DATA, 8'h00);
      send_request(KIND_DATA, 8'hFF);
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, CH_N);
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, 8'hFF);
   endtask

   // The largest two-byte and the largest three-byte encodings, then the closing quote.
   task automatic test_unicode_extremes();
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, CH_U);
      send_request(KIND_DATA, CH_ZERO);
      send_request(KIND_DATA, hex_char(4'h7, 1'b1));
      send_request(KIND_DATA, CH_UPPER_F);
      send_request(KIND_DATA, CH_UPPER_F);
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, CH_U);
      send_request(KIND_DATA, CH_LOWER_F);
      send_request(KIND_DATA, CH_LOWER_F);
      send_request(KIND_DATA, CH_LOWER_F);
      send_request(KIND_DATA, CH_LOWER_F);
      send_request(KIND_DATA, CH_QUOTE);
   endtask

   // End of input between strings, a missing opening quote, a bad hex digit
   // and end of input inside a string.
   task automatic test_error_cases();
      send_request(KIND_END, 8'hFF);
      send_request(KIND_DATA, CH_X);
      send_request(KIND_DATA, CH_QUOTE);
      send_request(KIND_DATA, CH_BACKSLASH);
      send_request(KIND_DATA, CH_U);
      send_request(KIND_DATA, CH_G);
      send_request(KIND_DATA, CH_QUOTE);
      send_request(KIND_END, 8'h00);
   endtask

   // Mostly well-formed strings with random content, mixed with broken strings and noise.
   task automatic test_random_strings();
      int first_request;
      int offset;
      int choice;
      logic [7:0] ch;
      first_request = requests_sent;
      while (requests_sent - first_request < RANDOM_ITEMS) begin
         offset = requests_sent - first_request;
         // A long run with neither side idling sits in the middle of the random part.
         no_gaps = (offset >= 120 && offset < 220);
         choice = $urandom_range(0, 99);
         if (choice < 78) begin
            send_request(KIND_DATA, CH_QUOTE);
            send_random_body($urandom_range(0, 10));
            send_request(KIND_DATA, CH_QUOTE);
         end else if (choice < 92) begin
            send_request(KIND_DATA, CH_QUOTE);
            send_random_body($urandom_range(0, 4));
            case ($urandom_range(0, 3))
               0: send_request(KIND_END, 8'($urandom_range(0, 255)));
               1: begin
                  send_request(KIND_DATA, CH_BACKSLASH);
                  send_request(KIND_END, 8'($urandom_range(0, 255)));
               end
               2: begin
                  send_unicode_escape(16'($urandom_range(0, 16'hFFFF)),
                                      $urandom_range(0, 3));
                  send_request(KIND_END, 8'($urandom_range(0, 255)));
               end
               default: begin
                  send_unicode_escape(16'($urandom_range(0, 16'hFFFF)),
                                      $urandom_range(0, 3));
                  do ch = 8'($urandom_range(0, 255)); while (hex_nibble(ch) >= 0);
                  send_request(KIND_DATA, ch);
               end
            endcase
         end else begin
            // Noise between strings: stray bytes or a lone end of input.
            if ($urandom_range(0, 2) == 0) begin
               send_request(KIND_END, 8'($urandom_range(0, 255)));
            end else begin
               do ch = 8'($urandom_range(0, 255)); while (ch == CH_QUOTE);
               send_request(KIND_DATA, ch);
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   // Each accepted result is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      decoded_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (rsp_tuser == RT_CLOSE) strings_closed++;
         if (rsp_tuser == RT_ERR) errors_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected result: byte %h type %0d last %0b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tuser !== want.result_type ||
                rsp_tlast !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("Result %0d: expected byte %h type %0d last %0b",
                           results_checked, want.out_byte, want.result_type,
                           want.last_of_run);
                  $display("   got byte %h type %0d last %0b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_and_escapes();
      test_unicode_extremes();
      test_error_cases();
      test_random_strings();

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) mismatches++;
      $display("Sent %0d requests and checked %0d results, %0d closed strings and %0d errors.",
               requests_sent, results_checked, strings_closed, errors_seen);
      $display("Stimulus mixed escapes, UTF-8 widths and broken strings under random stalls.");
      if (mismatches == 0) begin
         $display("json_string_unescape_utf8: match");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("json_string_unescape_utf8: mismatch");
      end
      $finish;
   end

endmodule
